### hdl/tcbp_pkg.sv
// ----------------------------------------------------------------------------
// tcbp_pkg
// Shared widths, register codes and types of the constant border padder.
// ----------------------------------------------------------------------------
package tcbp_pkg;

  // field widths
  localparam int ELEM_W  = 32;
  localparam int RUN_W   = 25;
  localparam int IDX_W   = 8;
  localparam int DIM_W   = 12;
  localparam int PAD_W   = 8;
  localparam int CPAD_W  = 4;
  localparam int OUTD_W  = DIM_W + 1;

  // saturation of the channel pad counts
  localparam int MAX_CHANNEL_PAD = 8;

  // pad word table
  localparam int TABLE_DEPTH = 256;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int REG_W  = 3;

  // register indexes
  localparam logic [REG_W-1:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [REG_W-1:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [REG_W-1:0] REG_PAD_TOP    = 3'd2;
  localparam logic [REG_W-1:0] REG_PAD_BOTTOM = 3'd3;
  localparam logic [REG_W-1:0] REG_PAD_LEFT   = 3'd4;
  localparam logic [REG_W-1:0] REG_PAD_RIGHT  = 3'd5;
  localparam logic [REG_W-1:0] REG_PAD_FRONT  = 3'd6;
  localparam logic [REG_W-1:0] REG_PAD_BEHIND = 3'd7;

  // request types
  localparam logic REQ_ELEM  = 1'b0;
  localparam logic REQ_TABLE = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]  in_width;
    logic [DIM_W-1:0]  in_height;
    logic [PAD_W-1:0]  pad_top;
    logic [PAD_W-1:0]  pad_bottom;
    logic [PAD_W-1:0]  pad_left;
    logic [PAD_W-1:0]  pad_right;
    logic [CPAD_W-1:0] pad_front;
    logic [CPAD_W-1:0] pad_behind;
  } cfg_t;

  // classified word common to all stages
  typedef struct packed {
    logic              wr;
    logic [ELEM_W-1:0] value;
    logic [IDX_W-1:0]  ch_front;
    logic [IDX_W-1:0]  ch_elem;
    logic [IDX_W-1:0]  ch_behind;
    logic [CPAD_W-1:0] n_front;
    logic [CPAD_W-1:0] n_behind;
  } item_t;

  typedef struct packed {
    item_t             item;
    logic [OUTD_W-1:0] outw;
    logic [OUTD_W-1:0] outh;
    logic [PAD_W-1:0]  pre_a;
    logic [PAD_W-1:0]  pre_add;
    logic [OUTD_W-1:0] post_b;
    logic [OUTD_W-1:0] post_add;
  } s1_t;

  typedef struct packed {
    item_t                   item;
    logic [PAD_W+OUTD_W-1:0] pre_prod;
    logic [PAD_W-1:0]        pre_add;
    logic [RUN_W-1:0]        post_prod;
    logic [OUTD_W-1:0]       post_add;
    logic [RUN_W-1:0]        plane;
  } s2_t;

  typedef struct packed {
    item_t            item;
    logic [RUN_W-1:0] pre_len;
    logic [RUN_W-1:0] post_len;
    logic [RUN_W-1:0] plane;
  } qent_t;

endpackage

### hdl/tcbp_if.sv
// ----------------------------------------------------------------------------
// tcbp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface tcbp_req_if import tcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ELEM_W-1:0] elem_value;
  logic [IDX_W-1:0]  table_index;
  logic              last_in_tensor;

  modport source(output valid, req_type, elem_value, table_index, last_in_tensor,
                 input ready);
  modport sink(input valid, req_type, elem_value, table_index, last_in_tensor,
               output ready);
endinterface

interface tcbp_res_if import tcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] out_value;
  logic [RUN_W-1:0]  run_length;
  logic              is_padding;
  logic              last_result;

  modport source(output valid, out_value, run_length, is_padding, last_result,
                 input ready);
  modport sink(input valid, out_value, run_length, is_padding, last_result,
               output ready);
endinterface

### hdl/tensor_constant_border_padder_unit.sv
// ----------------------------------------------------------------------------
// tensor_constant_border_padder_unit
// Constant border padding of a 3-D tensor streamed in raster order.
// ----------------------------------------------------------------------------
// Source elements enter one word per cycle while the queue has room, and each
// turns into its share of the padded output: front pad channels, the run ahead
// of it, the copied element, the run after it and behind pad channels, each pad
// run carrying the table word of its output channel. Interior elements give one
// result word. In the back sequencer every pad run first reads the word from
// the single-port table and then hands it to the output register; the
// four-deep queue lets the front keep accepting meanwhile. Table writes give
// no result. On the way to the queue the front classifies, multiplies and
// adds. Table entries that were never written read back as arbitrary data;
// there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module tensor_constant_border_padder_unit import tcbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  tcbp_req_if.sink          req_i,
  tcbp_res_if.source        res_o
);

  cfg_t  cfg;
  logic  push_valid, push_ready, pop_valid, pop;
  qent_t push_data, pop_data;

  // configuration registers
  tcbp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // classify and size runs
  tcbp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .req_i     (req_i),
    .q_valid_o (push_valid),
    .q_ready_i (push_ready),
    .q_data_o  (push_data)
  );

  // decoupling queue
  tcbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  // result sequencer
  tcbp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_pop_o   (pop),
    .q_data_i  (pop_data),
    .res_o     (res_o)
  );

endmodule

### hdl/tcbp_regs.sv
// ----------------------------------------------------------------------------
// tcbp_regs
// APB register file holding the tensor geometry and pad amounts.
// ----------------------------------------------------------------------------
module tcbp_regs import tcbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t             cfg_q, cfg_d;
  logic [REG_W-1:0] sel;
  logic             wr_en;

  assign pready = 1'b1;
  assign sel    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_IN_WIDTH:   cfg_d.in_width   = pwdata[DIM_W-1:0];
        REG_IN_HEIGHT:  cfg_d.in_height  = pwdata[DIM_W-1:0];
        REG_PAD_TOP:    cfg_d.pad_top    = pwdata[PAD_W-1:0];
        REG_PAD_BOTTOM: cfg_d.pad_bottom = pwdata[PAD_W-1:0];
        REG_PAD_LEFT:   cfg_d.pad_left   = pwdata[PAD_W-1:0];
        REG_PAD_RIGHT:  cfg_d.pad_right  = pwdata[PAD_W-1:0];
        REG_PAD_FRONT:  cfg_d.pad_front  = pwdata[CPAD_W-1:0];
        REG_PAD_BEHIND: cfg_d.pad_behind = pwdata[CPAD_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{in_width: DIM_W'(1), in_height: DIM_W'(1), default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (sel)
      REG_IN_WIDTH:   prdata = APB_DW'(cfg_q.in_width);
      REG_IN_HEIGHT:  prdata = APB_DW'(cfg_q.in_height);
      REG_PAD_TOP:    prdata = APB_DW'(cfg_q.pad_top);
      REG_PAD_BOTTOM: prdata = APB_DW'(cfg_q.pad_bottom);
      REG_PAD_LEFT:   prdata = APB_DW'(cfg_q.pad_left);
      REG_PAD_RIGHT:  prdata = APB_DW'(cfg_q.pad_right);
      REG_PAD_FRONT:  prdata = APB_DW'(cfg_q.pad_front);
      REG_PAD_BEHIND: prdata = APB_DW'(cfg_q.pad_behind);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/tcbp_front.sv
// ----------------------------------------------------------------------------
// tcbp_front
// Accepts request words, tracks position in the tensor and works out run
// lengths and channels for each word in a classify stage and a multiply stage.
// ----------------------------------------------------------------------------
module tcbp_front import tcbp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfg_t           cfg_i,
  tcbp_req_if.sink       req_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output qent_t          q_data_o
);

  // position state
  logic             open_q, open_d;
  logic [DIM_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [IDX_W-1:0] ch_q, ch_d;

  // stage registers
  logic s1_valid_q, s2_valid_q;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  logic s1_ready, s2_ready, accept;

  // classification signals
  logic [DIM_W-1:0]  w, h, col, row, cols_left, rows_left;
  logic [CPAD_W-1:0] f_sat, b_sat;
  logic              first, last, col_end, row_end, plane_end;
  logic              first_col, first_row;
  logic [IDX_W-1:0]  ch_elem, ch_behind;
  logic [2*OUTD_W-1:0] plane_full, post_full;

  assign s2_ready    = !s2_valid_q || q_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign req_i.ready = s1_ready;
  assign accept      = req_i.valid && s1_ready;

  // classify the incoming word
  always_comb begin
    w     = (cfg_i.in_width == '0) ? DIM_W'(1) : cfg_i.in_width;
    h     = (cfg_i.in_height == '0) ? DIM_W'(1) : cfg_i.in_height;
    f_sat = (cfg_i.pad_front > CPAD_W'(MAX_CHANNEL_PAD)) ? CPAD_W'(MAX_CHANNEL_PAD)
                                                          : cfg_i.pad_front;
    b_sat = (cfg_i.pad_behind > CPAD_W'(MAX_CHANNEL_PAD)) ? CPAD_W'(MAX_CHANNEL_PAD)
                                                           : cfg_i.pad_behind;
    first     = !open_q;
    last      = req_i.last_in_tensor;
    col       = first ? '0 : col_q;
    row       = first ? '0 : row_q;
    first_col = (col == '0);
    first_row = (row == '0);
    col_end   = ({1'b0, col} + OUTD_W'(1)) >= {1'b0, w};
    row_end   = ({1'b0, row} + OUTD_W'(1)) >= {1'b0, h};
    cols_left = col_end ? '0 : (w - DIM_W'(1) - col);
    rows_left = row_end ? '0 : (h - DIM_W'(1) - row);
    plane_end = last || (col_end && row_end);
    ch_elem   = ch_q + (first ? IDX_W'(f_sat) : '0);
    ch_behind = ch_elem + IDX_W'(plane_end);

    s1_d                = '0;
    s1_d.item.wr        = (req_i.req_type == REQ_TABLE);
    s1_d.item.value     = req_i.elem_value;
    s1_d.item.ch_front  = (req_i.req_type == REQ_TABLE) ? req_i.table_index : ch_q;
    s1_d.item.ch_elem   = ch_elem;
    s1_d.item.ch_behind = ch_behind;
    s1_d.item.n_front   = first ? f_sat : '0;
    s1_d.item.n_behind  = last ? b_sat : '0;
    s1_d.outw    = OUTD_W'(w) + OUTD_W'(cfg_i.pad_left) + OUTD_W'(cfg_i.pad_right);
    s1_d.outh    = OUTD_W'(h) + OUTD_W'(cfg_i.pad_top) + OUTD_W'(cfg_i.pad_bottom);
    s1_d.pre_a   = (first_col && first_row) ? cfg_i.pad_top : '0;
    s1_d.pre_add = first_col ? cfg_i.pad_left : '0;
    if (last) begin
      s1_d.post_b   = OUTD_W'(rows_left) + OUTD_W'(cfg_i.pad_bottom);
      s1_d.post_add = OUTD_W'(cols_left) + OUTD_W'(cfg_i.pad_right);
    end else if (col_end) begin
      s1_d.post_b   = row_end ? OUTD_W'(cfg_i.pad_bottom) : '0;
      s1_d.post_add = OUTD_W'(cfg_i.pad_right);
    end
  end

  // next position
  always_comb begin
    open_d = open_q;
    col_d  = col_q;
    row_d  = row_q;
    ch_d   = ch_q;
    if (accept && (req_i.req_type == REQ_ELEM)) begin
      open_d = !last;
      ch_d   = last ? '0 : ch_behind;
      if (plane_end) begin
        col_d = '0;
        row_d = '0;
      end else if (col_end) begin
        col_d = '0;
        row_d = row + DIM_W'(1);
      end else begin
        col_d = col + DIM_W'(1);
        row_d = row;
      end
    end
  end

  // products
  always_comb begin
    plane_full     = s1_q.outw * s1_q.outh;
    post_full      = s1_q.post_b * s1_q.outw;
    s2_d.item      = s1_q.item;
    s2_d.pre_prod  = s1_q.pre_a * s1_q.outw;
    s2_d.pre_add   = s1_q.pre_add;
    s2_d.post_prod = post_full[RUN_W-1:0];
    s2_d.post_add  = s1_q.post_add;
    s2_d.plane     = plane_full[RUN_W-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      ch_q       <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      open_q <= open_d;
      col_q  <= col_d;
      row_q  <= row_d;
      ch_q   <= ch_d;
      if (s1_ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  // final run lengths into the queue
  assign q_valid_o         = s2_valid_q;
  assign q_data_o.item     = s2_q.item;
  assign q_data_o.pre_len  = RUN_W'(s2_q.pre_prod) + RUN_W'(s2_q.pre_add);
  assign q_data_o.post_len = s2_q.post_prod + RUN_W'(s2_q.post_add);
  assign q_data_o.plane    = s2_q.plane;

endmodule

### hdl/tcbp_queue.sv
// ----------------------------------------------------------------------------
// tcbp_queue
// Short first-in first-out buffer of classified words between front and back.
// ----------------------------------------------------------------------------
module tcbp_queue import tcbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  qent_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_i,
  output qent_t pop_data_o
);

  qent_t             slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = slots_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/tcbp_back.sv
// ----------------------------------------------------------------------------
// tcbp_back
// Walks each classified word through its result sequence, writes table words,
// reads pad words from the table and holds the result word in an output register.
// ----------------------------------------------------------------------------
module tcbp_back import tcbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  output logic     q_pop_o,
  input  qent_t    q_data_i,
  tcbp_res_if.source res_o
);

  localparam logic [2:0] PH_FRONT  = 3'd0;
  localparam logic [2:0] PH_PRE    = 3'd1;
  localparam logic [2:0] PH_ELEM   = 3'd2;
  localparam logic [2:0] PH_POST   = 3'd3;
  localparam logic [2:0] PH_BEHIND = 3'd4;

  logic [ELEM_W-1:0] table_mem [TABLE_DEPTH];
  logic [ELEM_W-1:0] rd_q;

  logic              busy_q, busy_d;
  logic [2:0]        ph_q, ph_d, ph, start_ph, nxt_ph;
  logic [CPAD_W-1:0] cnt_q, cnt_d, cnt, nxt_cnt, cnt_inc;
  logic              fetched_q, fetched_d;

  logic [IDX_W-1:0]  addr;
  logic [RUN_W-1:0]  len;
  logic              fin, is_pad;
  logic              can_out, do_write, do_fetch, do_emit, pop;

  // output register
  logic              out_valid_q;
  logic [ELEM_W-1:0] out_value_q;
  logic [RUN_W-1:0]  run_length_q;
  logic              is_padding_q, last_result_q;

  // current step of the head word
  always_comb begin
    if (q_data_i.item.n_front != '0) begin
      start_ph = PH_FRONT;
    end else if (q_data_i.pre_len != '0) begin
      start_ph = PH_PRE;
    end else begin
      start_ph = PH_ELEM;
    end
    ph      = busy_q ? ph_q : start_ph;
    cnt     = busy_q ? cnt_q : '0;
    cnt_inc = cnt + CPAD_W'(1);
    addr    = q_data_i.item.ch_elem;
    len     = RUN_W'(1);
    fin     = 1'b0;
    nxt_ph  = PH_ELEM;
    nxt_cnt = '0;
    is_pad  = 1'b1;
    case (ph)
      PH_FRONT: begin
        addr = q_data_i.item.ch_front + IDX_W'(cnt);
        len  = q_data_i.plane;
        if (cnt_inc < q_data_i.item.n_front) begin
          nxt_ph  = PH_FRONT;
          nxt_cnt = cnt_inc;
        end else begin
          nxt_ph = (q_data_i.pre_len != '0) ? PH_PRE : PH_ELEM;
        end
      end
      PH_PRE: begin
        len    = q_data_i.pre_len;
        nxt_ph = PH_ELEM;
      end
      PH_ELEM: begin
        is_pad = 1'b0;
        fin    = (q_data_i.post_len == '0) && (q_data_i.item.n_behind == '0);
        nxt_ph = (q_data_i.post_len != '0) ? PH_POST : PH_BEHIND;
      end
      PH_POST: begin
        len    = q_data_i.post_len;
        fin    = (q_data_i.item.n_behind == '0);
        nxt_ph = PH_BEHIND;
      end
      PH_BEHIND: begin
        addr    = q_data_i.item.ch_behind + IDX_W'(cnt);
        len     = q_data_i.plane;
        fin     = (cnt_inc >= q_data_i.item.n_behind);
        nxt_ph  = PH_BEHIND;
        nxt_cnt = cnt_inc;
      end
      default: begin
        is_pad = 1'b0;
        fin    = 1'b1;
      end
    endcase
  end

  // step control
  assign can_out  = !out_valid_q || res_o.ready;
  assign do_write = q_valid_i && q_data_i.item.wr;
  assign do_fetch = q_valid_i && !q_data_i.item.wr && is_pad && !fetched_q;
  assign do_emit  = q_valid_i && !q_data_i.item.wr && can_out && (!is_pad || fetched_q);
  assign pop      = do_write || (do_emit && fin);
  assign q_pop_o  = pop;

  always_comb begin
    busy_d    = busy_q;
    ph_d      = ph_q;
    cnt_d     = cnt_q;
    fetched_d = fetched_q;
    if (do_fetch) begin
      fetched_d = 1'b1;
    end
    if (do_emit) begin
      busy_d    = !fin;
      ph_d      = nxt_ph;
      cnt_d     = nxt_cnt;
      fetched_d = 1'b0;
    end
    if (pop) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ph_q        <= PH_ELEM;
      cnt_q       <= '0;
      fetched_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      ph_q      <= ph_d;
      cnt_q     <= cnt_d;
      fetched_q <= fetched_d;
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pad word table
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      table_mem[q_data_i.item.ch_front] <= q_data_i.item.value;
    end
    if (do_fetch) begin
      rd_q <= table_mem[addr];
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      out_value_q   <= is_pad ? rd_q : q_data_i.item.value;
      run_length_q  <= len;
      is_padding_q  <= is_pad;
      last_result_q <= fin;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.out_value   = out_value_q;
  assign res_o.run_length  = run_length_q;
  assign res_o.is_padding  = is_padding_q;
  assign res_o.last_result = last_result_q;

endmodule
